// ===== rtl/core/shaded_palette_entry_generator_macros.svh =====
// ---------------------------------------------------------------------------
// Shaded palette entry generator: assertion macros
// Clocked assertion shorthands shared by the checker.
// ---------------------------------------------------------------------------
`ifndef SHADED_PALETTE_ENTRY_GENERATOR_MACROS_SVH
`define SHADED_PALETTE_ENTRY_GENERATOR_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define SPEG_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPEG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/spe_pkg.sv =====
// ---------------------------------------------------------------------------
// Shaded palette entry generator: package
// Pixel format codes, register indexes, field widths and beat structs.
// ---------------------------------------------------------------------------
`default_nettype none

package spe_pkg;

  localparam int CH_W        = 8;
  localparam int IDX_W       = 8;
  localparam int DAC_W       = 6;
  localparam int WORD_W      = 24;
  localparam int PROD_W      = 2 * CH_W;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int FMT_W       = 3;

  // Right shifts applied to grey * base
  localparam int SH_DAC   = 10;
  localparam int SH_PACK5 = 11;
  localparam int SH_PACK6 = 10;
  localparam int SH_TRUE  = 8;

  localparam logic [CH_W-1:0] BASE_RESET = 8'd255;

  typedef enum logic [FMT_W-1:0] {
    FMT_INDEXED = 3'd0,
    FMT_RGB555  = 3'd1,
    FMT_RGB565  = 3'd2,
    FMT_RGB24   = 3'd3,
    FMT_RGB32   = 3'd4
  } pix_fmt_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PIXEL_FORMAT = 3'd0,
    CFG_BASE_RED     = 3'd1,
    CFG_BASE_GREEN   = 3'd2,
    CFG_BASE_BLUE    = 3'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_SHADE  = 1'b0,
    CMD_DIRECT = 1'b1
  } cmd_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] entry_index;
    logic [CH_W-1:0]  grey;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last_entry;
  } item_t;

  typedef struct packed {
    logic [FMT_W-1:0] pixel_format;
    logic [CH_W-1:0]  base_red;
    logic [CH_W-1:0]  base_green;
    logic [CH_W-1:0]  base_blue;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  out_index;
    logic [DAC_W-1:0]  dac_red;
    logic [DAC_W-1:0]  dac_green;
    logic [DAC_W-1:0]  dac_blue;
    logic [WORD_W-1:0] pixel_word;
    logic              last_out;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== rtl/core/spe_if.sv =====
// ---------------------------------------------------------------------------
// Shaded palette entry generator: channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface spe_in_if import spe_pkg::*;;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [IDX_W-1:0] entry_index;
  logic [CH_W-1:0]  grey;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic             last_entry;

  modport source (
    output valid, cmd, entry_index, grey, red, green, blue, last_entry,
    input  ready
  );
  modport sink (
    input  valid, cmd, entry_index, grey, red, green, blue, last_entry,
    output ready
  );
endinterface

interface spe_out_if import spe_pkg::*;;
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  out_index;
  logic [DAC_W-1:0]  dac_red;
  logic [DAC_W-1:0]  dac_green;
  logic [DAC_W-1:0]  dac_blue;
  logic [WORD_W-1:0] pixel_word;
  logic              last_out;

  modport source (
    output valid, out_index, dac_red, dac_green, dac_blue, pixel_word, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_index, dac_red, dac_green, dac_blue, pixel_word, last_out,
    output ready
  );
endinterface

interface spe_cfg_if import spe_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spe_convert.sv =====
// ---------------------------------------------------------------------------
// Shaded palette entry generator: entry conversion
// Scales or truncates one colour and packs it for the selected pixel format.
// ---------------------------------------------------------------------------
`default_nettype none

module spe_convert import spe_pkg::*; (
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;
  logic              direct;

  // Three independent 8x8 products
  assign prod_r = PROD_W'(item.grey) * PROD_W'(cfg.base_red);
  assign prod_g = PROD_W'(item.grey) * PROD_W'(cfg.base_green);
  assign prod_b = PROD_W'(item.grey) * PROD_W'(cfg.base_blue);
  assign direct = (item.cmd == CMD_DIRECT);

  always_comb begin
    res            = '0;
    res.out_index  = item.entry_index;
    res.last_out   = item.last_entry;
    unique case (cfg.pixel_format)
      FMT_INDEXED: begin
        res.dac_red    = direct ? item.red[CH_W-1 -: DAC_W]   : DAC_W'(prod_r >> SH_DAC);
        res.dac_green  = direct ? item.green[CH_W-1 -: DAC_W] : DAC_W'(prod_g >> SH_DAC);
        res.dac_blue   = direct ? item.blue[CH_W-1 -: DAC_W]  : DAC_W'(prod_b >> SH_DAC);
        res.pixel_word = WORD_W'(item.entry_index);
      end
      FMT_RGB555: begin
        res.pixel_word = WORD_W'({
          direct ? item.red[CH_W-1 -: 5]   : 5'(prod_r >> SH_PACK5),
          direct ? item.green[CH_W-1 -: 5] : 5'(prod_g >> SH_PACK5),
          direct ? item.blue[CH_W-1 -: 5]  : 5'(prod_b >> SH_PACK5)
        });
      end
      FMT_RGB565: begin
        res.pixel_word = WORD_W'({
          direct ? item.red[CH_W-1 -: 5]   : 5'(prod_r >> SH_PACK5),
          direct ? item.green[CH_W-1 -: 6] : 6'(prod_g >> SH_PACK6),
          direct ? item.blue[CH_W-1 -: 5]  : 5'(prod_b >> SH_PACK5)
        });
      end
      default: begin
        // true colour; undefined codes fall here as well
        res.pixel_word = {
          direct ? item.red   : CH_W'(prod_r >> SH_TRUE),
          direct ? item.green : CH_W'(prod_g >> SH_TRUE),
          direct ? item.blue  : CH_W'(prod_b >> SH_TRUE)
        };
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/shaded_palette_entry_generator.sv =====
// ---------------------------------------------------------------------------
// Shaded palette entry generator
// Turns each input beat into one colour-map entry for the configured display
// pixel format. In shade mode the grey level scales the base colour per
// channel; in direct mode the given RGB triple is truncated. Indexed mode
// gives a 6-bit DAC triple with the entry index as pixel value, the packed
// modes a 555 or 565 word, true colour R<<16|G<<8|B. The block takes one
// beat per clock unless the result sink stalls it, and returns one result
// beat for each, in order. A beat passes through the input register, then
// three 8x8 multiplies and the packing logic, then the result register.
// The result and input registers form a two-deep pipeline, so an input
// beat is accepted while a finished result still waits downstream. Register
// writes are always taken and act on beats converted after the write.
// ---------------------------------------------------------------------------
`default_nettype none

module shaded_palette_entry_generator import spe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  spe_in_if.sink    items,
  spe_out_if.source results,
  spe_cfg_if.sink   cfg
);

  cfg_t    cfg_regs;

  logic    s1_valid;
  item_t   s1_item;
  logic    out_valid;
  result_t out_res;
  result_t conv_res;

  logic    in_load;
  logic    out_load;

  // -------------------------------------------------------------------------
  // Configuration registers: never stall a write
  // -------------------------------------------------------------------------
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.pixel_format <= FMT_INDEXED;
      cfg_regs.base_red     <= BASE_RESET;
      cfg_regs.base_green   <= BASE_RESET;
      cfg_regs.base_blue    <= BASE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_PIXEL_FORMAT: cfg_regs.pixel_format <= cfg.data[FMT_W-1:0];
        CFG_BASE_RED:     cfg_regs.base_red     <= cfg.data;
        CFG_BASE_GREEN:   cfg_regs.base_green   <= cfg.data;
        CFG_BASE_BLUE:    cfg_regs.base_blue    <= cfg.data;
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Handshake: advance the result register when it is empty or being taken,
  // and refill the input register whenever its beat moves on.
  // -------------------------------------------------------------------------
  assign out_load    = s1_valid && (!out_valid || results.ready);
  assign items.ready = !s1_valid || out_load;
  assign in_load     = items.valid && items.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_load) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Input register: capture the beat as it is accepted
  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_item.cmd         <= items.cmd;
      s1_item.entry_index <= items.entry_index;
      s1_item.grey        <= items.grey;
      s1_item.red         <= items.red;
      s1_item.green       <= items.green;
      s1_item.blue        <= items.blue;
      s1_item.last_entry  <= items.last_entry;
    end
  end

  // Scale or truncate and pack for the current format
  spe_convert u_convert (
    .item (s1_item),
    .cfg  (cfg_regs),
    .res  (conv_res)
  );

  // Result register: hold until the sink takes the beat
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= conv_res;
    end
  end

  assign results.valid      = out_valid;
  assign results.out_index  = out_res.out_index;
  assign results.dac_red    = out_res.dac_red;
  assign results.dac_green  = out_res.dac_green;
  assign results.dac_blue   = out_res.dac_blue;
  assign results.pixel_word = out_res.pixel_word;
  assign results.last_out   = out_res.last_out;

endmodule

`default_nettype wire

// ===== rtl/core/spe_checker.sv =====
// ---------------------------------------------------------------------------
// Shaded palette entry generator: port checker
// Watches the top-level channels and the beats in flight between them.
// ---------------------------------------------------------------------------
`default_nettype none

`include "shaded_palette_entry_generator_macros.svh"

module spe_checker import spe_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                cfg_ready,
  input logic [RESULT_W-1:0] out_payload
);

  logic [1:0] in_flight;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  // Count beats accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 2'd0;
    end else begin
      in_flight <= in_flight + 2'(in_beat) - 2'(out_beat);
    end
  end

  `SPEG_ASSERT_ALWAYS(a_no_invented, clk, rst, !out_valid || (in_flight != 2'd0), "result beat without an accepted input")
  `SPEG_ASSERT_ALWAYS(a_depth, clk, rst, in_flight <= 2'd2, "more than two beats in flight")
  `SPEG_ASSERT_ALWAYS(a_cfg_ready, clk, rst, cfg_ready, "register write stalled")
  `SPEG_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result valid dropped while stalled")
  `SPEG_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_payload), "result payload changed while stalled")

endmodule

bind shaded_palette_entry_generator spe_checker u_spe_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (items.valid),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .cfg_ready   (cfg.ready),
  .out_payload ({results.out_index, results.dac_red, results.dac_green,
                 results.dac_blue, results.pixel_word, results.last_out})
);

`default_nettype wire
